// ===== src/sis_pkg.sv =====
// ----------------------------------------------------------------------------
// sis_pkg
// Shared types and codes for the sorted integer set: word layouts of the
// command and result channels, command codes and controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package sis_pkg;

	localparam int unsigned VALUE_W     = 32;
	localparam int unsigned COUNT_OUT_W = 7;

	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_DELETE = 2'd1;

	typedef struct packed {
		logic [1:0]                command;
		logic signed [VALUE_W-1:0] value;
	} item_t;

	typedef struct packed {
		logic                      was_present;
		logic                      full_reject;
		logic [COUNT_OUT_W-1:0]    entry_count;
		logic signed [VALUE_W-1:0] mean_value;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_CMP,
		ST_DECIDE,
		ST_INS,
		ST_DEL,
		ST_DIV,
		ST_WAIT
	} state_t;

endpackage

`default_nettype wire

// ===== src/sis_ram.sv =====
// ----------------------------------------------------------------------------
// sis_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module sis_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== src/sis_div.sv =====
// ----------------------------------------------------------------------------
// sis_div
// Iterative signed-by-unsigned divider, one quotient bit per cycle.
// Restoring division on the magnitude; quotient truncated toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module sis_div #(
	parameter int unsigned NW = 38,
	parameter int unsigned DW = 7
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic signed [NW-1:0] dividend,
	input  wire logic [DW-1:0]        divisor,
	output logic                      done,
	output logic signed [NW-1:0]      quotient
);

	localparam int unsigned STW = $clog2(NW);

	logic            run_q;
	logic            done_q;
	logic [STW-1:0]  step_q;
	logic            neg_q;
	logic [NW-1:0]   quo_q;
	logic [DW-1:0]   rem_q;
	logic [DW:0]     trial;
	logic [DW:0]     diff;
	logic            qbit;

	assign trial = {rem_q, quo_q[NW-1]};
	assign diff  = trial - {1'b0, divisor};
	assign qbit  = (trial >= {1'b0, divisor});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				step_q <= step_q + STW'(1);
				if (step_q == STW'(NW - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[NW-1];
			quo_q <= dividend[NW-1] ? NW'(-dividend) : NW'(dividend);
			rem_q <= '0;
		end else if (run_q) begin
			// shift in the next dividend bit, subtract when it fits
			rem_q <= qbit ? diff[DW-1:0] : trial[DW-1:0];
			quo_q <= {quo_q[NW-2:0], qbit};
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? -signed'(quo_q) : signed'(quo_q);

endmodule

`default_nettype wire

// ===== src/sorted_integer_set_top.sv =====
// Processing: a binary search over the n stored entries, a search and a compare
// state per step, then one entry moved per cycle for an insert or delete, then
// the divider for the mean, which is skipped when the set is empty.
// One word is processed at a time, with busy high throughout.
// The result strobe lasts one cycle; the receiver cannot stall and the next word
// may be started in that cycle. Reset empties the set at once, with no sweep.
// ----------------------------------------------------------------------------
// sorted_integer_set_top
// Sorted set of distinct signed integers kept in one RAM, with insert, delete
// and lookup, reporting presence, count and truncated mean of the entries.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_integer_set_top
	import sis_pkg::*;
#(
	parameter int unsigned CAPACITY = 64
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  start,
	input  wire item_t item,
	output logic       busy,
	output logic       done,
	output result_t    result
);

	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned AW = $clog2(CAPACITY);
	localparam int unsigned SW = VALUE_W + $clog2(CAPACITY);

	state_t                   state_q, state_d;
	logic [1:0]               cmd_q;
	logic signed [VALUE_W-1:0] val_q;
	logic [CW-1:0]            lo_q, hi_q, idx_q, cnt_q;
	logic [AW-1:0]            wr_addr_q;
	logic                     pend_q, found_q, reject_q, done_q;
	logic signed [SW-1:0]     sum_q;
	result_t                  result_q;

	logic [CW:0]              mid_sum;
	logic [CW-1:0]            mid;
	logic [CW-1:0]            ins_rd, del_rd;
	logic [VALUE_W-1:0]       rd_data;
	logic signed [VALUE_W-1:0] rd_val;
	logic                     ram_we;
	logic [AW-1:0]            ram_waddr, ram_raddr;
	logic [VALUE_W-1:0]       ram_wdata;
	logic                     div_start, div_done;
	logic signed [SW-1:0]     div_quo;
	logic                     is_full, ins_new, del_hit;

	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid     = mid_sum[CW:1];
	assign ins_rd  = idx_q - CW'(1);
	assign del_rd  = idx_q + CW'(1);
	assign rd_val  = signed'(rd_data);
	assign is_full = (cnt_q == CW'(CAPACITY));
	assign ins_new = (cmd_q == CMD_INSERT) && !found_q;
	assign del_hit = (cmd_q == CMD_DELETE) && found_q;

	sis_ram #(
		.WIDTH(VALUE_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (rd_data)
	);

	sis_div #(
		.NW(SW),
		.DW(CW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q),
		.divisor  (cnt_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = wr_addr_q;
		ram_wdata = rd_data;
		ram_raddr = '0;
		div_start = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (lo_q < hi_q) begin
					ram_raddr = mid[AW-1:0];
					state_d   = ST_CMP;
				end else begin
					state_d = ST_DECIDE;
				end
			end
			ST_CMP: begin
				state_d = ST_SEARCH;
			end
			ST_DECIDE: begin
				if (ins_new && !is_full) begin
					state_d = ST_INS;
				end else if (del_hit) begin
					state_d = ST_DEL;
				end else begin
					state_d = ST_DIV;
				end
			end
			ST_INS: begin
				// walk down from the top, one entry moved up per cycle
				ram_raddr = ins_rd[AW-1:0];
				if (pend_q) begin
					ram_we = 1'b1;
				end else if (idx_q == lo_q) begin
					ram_we    = 1'b1;
					ram_waddr = lo_q[AW-1:0];
					ram_wdata = val_q;
					state_d   = ST_DIV;
				end
			end
			ST_DEL: begin
				// walk up from the hole, one entry moved down per cycle
				ram_raddr = del_rd[AW-1:0];
				if (pend_q) begin
					ram_we = 1'b1;
				end
				if (del_rd >= cnt_q) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (cnt_q == '0) begin
					state_d = ST_IDLE;
				end else begin
					div_start = 1'b1;
					state_d   = ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (div_done) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			sum_q  <= '0;
			pend_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					pend_q <= 1'b0;
				end
				ST_INS: begin
					if (idx_q != lo_q) begin
						pend_q <= 1'b1;
					end else begin
						pend_q <= 1'b0;
						if (!pend_q) begin
							cnt_q <= cnt_q + CW'(1);
							sum_q <= sum_q + SW'(val_q);
						end
					end
				end
				ST_DEL: begin
					if (del_rd < cnt_q) begin
						pend_q <= 1'b1;
					end else begin
						pend_q <= 1'b0;
						cnt_q  <= cnt_q - CW'(1);
						sum_q  <= sum_q - SW'(val_q);
					end
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						done_q <= 1'b1;
					end
				end
				ST_WAIT: begin
					if (div_done) begin
						done_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd_q    <= item.command;
					val_q    <= item.value;
					lo_q     <= '0;
					hi_q     <= cnt_q;
					found_q  <= 1'b0;
					reject_q <= 1'b0;
				end
			end
			ST_CMP: begin
				if (rd_val < val_q) begin
					lo_q <= mid + CW'(1);
				end else begin
					hi_q <= mid;
				end
				if (rd_val == val_q) begin
					found_q <= 1'b1;
				end
			end
			ST_DECIDE: begin
				reject_q <= ins_new && is_full;
				idx_q    <= (cmd_q == CMD_INSERT) ? cnt_q : lo_q;
			end
			ST_INS: begin
				if (idx_q != lo_q) begin
					wr_addr_q <= idx_q[AW-1:0];
					idx_q     <= ins_rd;
				end
			end
			ST_DEL: begin
				if (del_rd < cnt_q) begin
					wr_addr_q <= idx_q[AW-1:0];
					idx_q     <= del_rd;
				end
			end
			ST_DIV: begin
				if (cnt_q == '0) begin
					result_q.was_present <= found_q;
					result_q.full_reject <= reject_q;
					result_q.entry_count <= COUNT_OUT_W'(cnt_q);
					result_q.mean_value  <= '0;
				end
			end
			ST_WAIT: begin
				if (div_done) begin
					result_q.was_present <= found_q;
					result_q.full_reject <= reject_q;
					result_q.entry_count <= COUNT_OUT_W'(cnt_q);
					result_q.mean_value  <= VALUE_W'(div_quo);
				end
			end
			default: begin
			end
		endcase
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule

`default_nettype wire

// ===== src/sis_chk.sv =====
// ----------------------------------------------------------------------------
// sis_chk
// Port-level checks on the sorted integer set: handshake timing and result
// consistency, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module sis_chk
	import sis_pkg::*;
#(
	parameter int unsigned CAPACITY = 64
) (
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    start,
	input wire logic    busy,
	input wire logic    done,
	input wire result_t result
);

	// a word that starts must hold the block busy next cycle
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted word did not raise busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_reject_new: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(result.full_reject && result.was_present))
		else $error("reject flagged for a value already present");

	a_empty_mean: assert property (@(posedge clk) disable iff (!arst_n)
		done && (CAPACITY < 128) && (result.entry_count == '0)
			|-> (result.mean_value == '0))
		else $error("nonzero mean on an empty set");

endmodule

bind sorted_integer_set_top sis_chk #(
	.CAPACITY(CAPACITY)
) u_sis_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);

`default_nettype wire

// ===== verif/sorted_integer_set_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_integer_set_top_tb
// Drives insert, delete and lookup words into the sorted set and checks
// every result word against a behavioral copy of the set. The copy holds the
// entries, their count and their running sum. The run covers a short list of
// corner values, then a full store with dropped inserts, then rounds that
// alternate between filling and draining the set from a pool of values.
// ----------------------------------------------------------------------------

module sorted_integer_set_top_tb
	import sis_pkg::*;
();

	localparam int unsigned SET_DEPTH   = 64;
	localparam int unsigned CYCLE_LIMIT = 2_000_000;
	localparam int unsigned TAIL_CYCLES = 200;
	localparam int unsigned IDLE_PCT    = 15;
	localparam int unsigned POOL_SIZE   = 96;
	localparam int unsigned ROUNDS      = 8;
	localparam int unsigned ROUND_WORDS = 190;

	localparam logic [1:0] CMD_LOOKUP = 2'd2;
	localparam logic [1:0] CMD_SPARE  = 2'd3;

	localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;

	typedef struct packed {
		item_t word;
		logic  hold_back;
	} pending_t;

	logic    clk      = 1'b0;
	logic    arst_n   = 1'b0;
	logic    start    = 1'b0;
	item_t   item_bus = '0;
	logic    busy;
	logic    done;
	result_t result_bus;

	pending_t          pending_words[$];
	result_t           expected_results[$];
	logic signed [31:0] set_entries[$];
	longint            set_sum        = 0;
	int unsigned       words_total    = 0;
	int unsigned       words_sent     = 0;
	int unsigned       words_accepted = 0;
	int unsigned       gap_left       = 0;
	int unsigned       mismatch_count = 0;
	logic              word_taken     = 1'b0;

	sorted_integer_set_top #(
		.CAPACITY(SET_DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.item(item_bus),
		.busy(busy),
		.done(done),
		.result(result_bus)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Apply one word to the set copy and return the result it should give.
	function automatic result_t set_apply(item_t w);
		int unsigned pos;
		logic        present;
		result_t     r;
		pos = 0;
		while (pos < set_entries.size() && set_entries[pos] < w.value)
			pos++;
		present = (pos < set_entries.size()) && (set_entries[pos] == w.value);
		r = '0;
		r.was_present = present;
		if (w.command == CMD_INSERT && !present) begin
			if (set_entries.size() >= SET_DEPTH) begin
				r.full_reject = 1'b1;
			end else begin
				set_entries.insert(pos, w.value);
				set_sum += w.value;
			end
		end else if (w.command == CMD_DELETE && present) begin
			set_entries.delete(pos);
			set_sum -= w.value;
		end
		r.entry_count = COUNT_OUT_W'(set_entries.size());
		if (set_entries.size() != 0)
			r.mean_value = VALUE_W'(set_sum / longint'(set_entries.size()));
		return r;
	endfunction

	function automatic void queue_word(logic [1:0] cmd, logic signed [31:0] val,
			logic hold);
		pending_t p;
		p.word.command = cmd;
		p.word.value   = val;
		p.hold_back    = hold;
		pending_words.push_back(p);
		words_total++;
	endfunction

	task automatic check_field(string field, logic signed [32:0] exp_v,
			logic signed [32:0] got_v);
		if (got_v !== exp_v) begin
			$display("%0t: %s expected %0d got %0d", $time, field, exp_v, got_v);
			mismatch_count++;
		end
	endtask

	// Driver: hold start until the word is taken, then idle or present the next.
	always @(negedge clk) begin
		if (arst_n) begin
			if (gap_left != 0)
				gap_left--;
			if (!start || word_taken) begin
				if (word_taken && !(words_sent >= 400 && words_sent < 700) &&
						$urandom_range(99) < IDLE_PCT)
					gap_left = $urandom_range(100, 1);
				if (pending_words.size() != 0 && gap_left == 0 &&
						!(pending_words[0].hold_back && expected_results.size() != 0)) begin
					item_bus <= pending_words[0].word;
					start    <= 1'b1;
					pending_words.pop_front();
					words_sent++;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: check the result word first, then record a newly taken word.
	always @(posedge clk) begin
		result_t exp_r;
		if (arst_n) begin
			word_taken = start && !busy;
			if (done) begin
				if (expected_results.size() == 0) begin
					$display("%0t: result with none expected, got %p", $time, result_bus);
					mismatch_count++;
				end else begin
					exp_r = expected_results.pop_front();
					check_field("was_present", 33'(exp_r.was_present),
						33'(result_bus.was_present));
					check_field("full_reject", 33'(exp_r.full_reject),
						33'(result_bus.full_reject));
					check_field("entry_count", 33'(exp_r.entry_count),
						33'(result_bus.entry_count));
					check_field("mean_value", 33'(exp_r.mean_value),
						33'(result_bus.mean_value));
				end
			end
			if (word_taken) begin
				expected_results.push_back(set_apply(item_bus));
				words_accepted++;
			end
		end
	end

	initial begin : watchdog
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("sorted_integer_set_top_tb: FAIL");
		$finish;
	end

	initial begin : stimulus
		logic signed [31:0] value_pool [POOL_SIZE];
		logic signed [31:0] val;
		logic [1:0]         cmd;
		int unsigned        insert_pct;
		int unsigned        roll;

		// Corner values, every command and the empty set
		queue_word(CMD_LOOKUP, 32'sd0, 1'b0);
		queue_word(CMD_DELETE, 32'sd5, 1'b0);
		queue_word(CMD_INSERT, VAL_MAX, 1'b0);
		queue_word(CMD_INSERT, VAL_MAX, 1'b0);
		queue_word(CMD_INSERT, VAL_MAX - 1, 1'b0);
		queue_word(CMD_INSERT, VAL_MIN, 1'b0);
		queue_word(CMD_INSERT, -32'sd1, 1'b0);
		queue_word(CMD_INSERT, 32'sd0, 1'b0);
		queue_word(CMD_SPARE, -32'sd1, 1'b0);
		queue_word(CMD_LOOKUP, VAL_MIN, 1'b0);
		queue_word(CMD_DELETE, 32'sd7, 1'b0);
		queue_word(CMD_INSERT, VAL_MIN + 1, 1'b0);
		queue_word(CMD_INSERT, -32'sd3, 1'b0);
		queue_word(CMD_DELETE, VAL_MAX, 1'b0);
		queue_word(CMD_DELETE, VAL_MAX - 1, 1'b0);
		queue_word(CMD_DELETE, VAL_MIN, 1'b0);
		queue_word(CMD_DELETE, VAL_MIN + 1, 1'b0);
		queue_word(CMD_DELETE, -32'sd1, 1'b0);
		queue_word(CMD_INSERT, 32'sd5, 1'b0);
		queue_word(CMD_INSERT, -32'sd8, 1'b0);
		queue_word(CMD_DELETE, 32'sd0, 1'b0);
		queue_word(CMD_DELETE, -32'sd3, 1'b0);
		queue_word(CMD_DELETE, 32'sd5, 1'b0);
		queue_word(CMD_DELETE, -32'sd8, 1'b0);

		// Fill the store with distinct values, then overflow it
		for (int k = 0; k < SET_DEPTH; k++)
			queue_word(CMD_INSERT, VAL_MIN + (k << 26) + $urandom_range((1 << 26) - 1, 0),
				k == 0);
		queue_word(CMD_INSERT, VAL_MIN + (SET_DEPTH << 26), 1'b0);
		queue_word(CMD_INSERT, VAL_MIN, 1'b0);
		queue_word(CMD_LOOKUP, VAL_MAX, 1'b0);

		// Alternate draining and filling rounds over a fresh value pool each
		for (int r = 0; r < ROUNDS; r++) begin
			for (int k = 0; k < POOL_SIZE; k++) begin
				case ($urandom_range(3))
					0: value_pool[k] = $urandom;
					1: value_pool[k] = $signed($urandom_range(40)) - 32'sd20;
					2: value_pool[k] = VAL_MIN + $urandom_range(7);
					default: value_pool[k] = VAL_MAX - $urandom_range(7);
				endcase
			end
			insert_pct = (r % 2 == 0) ? 25 : 80;
			for (int k = 0; k < ROUND_WORDS; k++) begin
				roll = $urandom_range(99);
				if (roll < insert_pct)
					cmd = CMD_INSERT;
				else if (roll < 90)
					cmd = CMD_DELETE;
				else if (roll < 97)
					cmd = CMD_LOOKUP;
				else
					cmd = CMD_SPARE;
				if ($urandom_range(99) < 80)
					val = value_pool[$urandom_range(POOL_SIZE - 1)];
				else
					val = $urandom;
				queue_word(cmd, val, k == 0);
			end
		end

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (words_accepted != words_total || expected_results.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		if (mismatch_count == 0 && expected_results.size() == 0)
			$display("sorted_integer_set_top_tb: PASS");
		else
			$display("sorted_integer_set_top_tb: FAIL");
		$finish;
	end

endmodule
